// ----- hdl/irmsp_pkg.sv -----
// ----------------------------------------------------------------------------
// irmsp_pkg
// Shared types, widths and codes of the infrared mark/space player.
// ----------------------------------------------------------------------------
package irmsp_pkg;

    // Ring geometry
    localparam int RING_DEPTH    = 256;
    localparam int DURATION_BITS = 28;
    localparam int PTR_W         = $clog2(RING_DEPTH);
    localparam int CNT_W         = PTR_W;

    // Field widths
    localparam int FUNC_W     = 2;
    localparam int DUR_W      = 28;
    localparam int ENTRY_W    = DUR_W + 1;
    localparam int MARK_BIT   = DUR_W;
    localparam int MARK_DUR_W = 16;
    localparam int TICK_W     = 10;
    localparam int CMP_W      = 16;
    localparam int TIME_W     = 30;
    localparam int ACC_W      = 11;
    localparam int MS_W       = 32;
    localparam int DROP_W     = 16;
    localparam int QCNT_W     = 8;
    localparam int QEXT_W     = (CNT_W > QCNT_W) ? CNT_W : QCNT_W;

    // Stream widths
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = FUNC_W;
    localparam int OUT_TDATA_W = 80;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [DUR_W-1:0] SPACE_MASK =
        DUR_W'((64'd1 << DURATION_BITS) - 64'd1);

    localparam int US_PER_MS = 1000;
    localparam int TIME_MAX  = (2 ** (TIME_W - 1)) - 1;
    localparam int TIME_MIN  = -(2 ** (TIME_W - 1));

    // Register reset values
    localparam logic [TICK_W-1:0] TICK_US_RST = TICK_W'(50);
    localparam logic [CMP_W-1:0]  PERIOD_RST  = CMP_W'(684);
    localparam logic [CMP_W-1:0]  DUTY_RST    = CMP_W'(342);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_MARK  = 2'd1,
        FUNC_SPACE = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_US        = 3'd0,
        CFG_CARRIER_PERIOD = 3'd1,
        CFG_CARRIER_DUTY   = 3'd2,
        CFG_INVERT_IDLE    = 3'd3,
        CFG_RX_WHILE_TX    = 3'd4
    } cfg_index_t;

    // Request from the player to the ring
    typedef struct packed {
        logic               push;
        logic               pop;
        logic               clear;
        logic [ENTRY_W-1:0] wdata;
    } ring_ctrl_t;

    // Ring status back to the player
    typedef struct packed {
        logic [ENTRY_W-1:0] head;
        logic               empty;
        logic               full;
        logic [CNT_W-1:0]   count_next;
    } ring_stat_t;

    // One result, pwm_compare in the lowest bits
    typedef struct packed {
        logic [MS_W-1:0]   elapsed_ms;
        logic [DROP_W-1:0] overflow_count;
        logic [QCNT_W-1:0] queue_count;
        logic              accepted;
        logic              receive_enable;
        logic              sending;
        logic              carrier_on;
        logic [CMP_W-1:0]  pwm_compare;
    } result_t;

endpackage

// ----- hdl/irmsp_ring.sv -----
// ----------------------------------------------------------------------------
// irmsp_ring
// Symbol ring in a synchronous memory with a registered head entry.
// ----------------------------------------------------------------------------
module irmsp_ring (
    input  logic                  clk,
    input  logic                  rst_n,
    input  irmsp_pkg::ring_ctrl_t ctrl,
    output irmsp_pkg::ring_stat_t stat
);
    import irmsp_pkg::*;

    logic [ENTRY_W-1:0] mem [RING_DEPTH];
    logic [ENTRY_W-1:0] head_reg;
    logic [PTR_W-1:0]   wp_reg;
    logic [PTR_W-1:0]   wp_next;
    logic [PTR_W-1:0]   rp_reg;
    logic [PTR_W-1:0]   rp_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               full;
    logic               empty;
    logic               do_push;
    logic               do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Decide pointer and count moves
    always_comb
    begin
        full    = (count_reg == CNT_W'(RING_DEPTH - 1));
        empty   = (count_reg == '0);
        do_push = ctrl.push & ~full;
        do_pop  = ctrl.pop & ~empty;
        if (ctrl.clear)
        begin
            wp_next    = '0;
            rp_next    = '0;
            count_next = '0;
        end
        else
        begin
            wp_next    = do_push ? ptr_inc(wp_reg) : wp_reg;
            rp_next    = do_pop ? ptr_inc(rp_reg) : rp_reg;
            count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    // Write the pushed entry; prefetch the next head, forward a same-address write
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wp_reg] <= ctrl.wdata;
        end
        if (do_push && (wp_reg == rp_next))
        begin
            head_reg <= ctrl.wdata;
        end
        else
        begin
            head_reg <= mem[rp_next];
        end
    end

    // Hold pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    assign stat.head       = head_reg;
    assign stat.empty      = empty;
    assign stat.full       = full;
    assign stat.count_next = count_next;

    // Count never passes the usable depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(RING_DEPTH - 1))
        else $error("ring count above usable depth");

    // An empty ring has both pointers together
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wp_reg == rp_reg))
        else $error("empty ring with split pointers");

    // A push into a full ring leaves the write pointer alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.push && full && !ctrl.clear) |=> $stable(wp_reg))
        else $error("write pointer moved on dropped push");

endmodule

// ----- hdl/irmsp_core.sv -----
// ----------------------------------------------------------------------------
// irmsp_core
// Playback control: configuration, symbol timer, millisecond clock, result.
// ----------------------------------------------------------------------------
module irmsp_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [irmsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [irmsp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 step,
    input  logic [irmsp_pkg::FUNC_W-1:0]         func,
    input  logic [irmsp_pkg::DUR_W-1:0]          duration_us,
    output irmsp_pkg::ring_ctrl_t                ring_ctrl,
    input  irmsp_pkg::ring_stat_t                ring_stat,
    output irmsp_pkg::result_t                   result
);
    import irmsp_pkg::*;

    // Configuration registers
    logic [TICK_W-1:0] tick_us_reg;
    logic [CMP_W-1:0]  period_reg;
    logic [CMP_W-1:0]  duty_reg;
    logic              invert_reg;
    logic              rx_tx_reg;

    // Player state
    logic signed [TIME_W-1:0] time_left_reg;
    logic signed [TIME_W-1:0] time_left_next;
    logic                     level_reg;
    logic                     level_next;
    logic [DROP_W-1:0]        drop_reg;
    logic [DROP_W-1:0]        drop_next;
    logic [ACC_W-1:0]         micro_reg;
    logic [ACC_W-1:0]         micro_next;
    logic [MS_W-1:0]          milli_reg;
    logic [MS_W-1:0]          milli_next;

    // Working values
    func_t                    fn;
    logic [ACC_W:0]           acc_sum;
    logic [ACC_W:0]           acc_adj;
    logic                     acc_over;
    logic signed [TIME_W:0]   t_sub;
    logic signed [TIME_W:0]   t_base;
    logic signed [TIME_W+1:0] t_pre;
    logic signed [TIME_W-1:0] t_clamped;
    logic                     tl_zero;
    logic                     want_pop;
    logic                     entry_zero;
    logic                     sending;
    logic                     rx_en;
    logic                     accepted;
    logic [QEXT_W-1:0]        qext;

    assign fn = func_t'(func);

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_us_reg <= TICK_US_RST;
            period_reg  <= PERIOD_RST;
            duty_reg    <= DUTY_RST;
            invert_reg  <= 1'b0;
            rx_tx_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_TICK_US:        tick_us_reg <= cfg_data[TICK_W-1:0];
                CFG_CARRIER_PERIOD: period_reg  <= cfg_data[CMP_W-1:0];
                CFG_CARRIER_DUTY:   duty_reg    <= cfg_data[CMP_W-1:0];
                CFG_INVERT_IDLE:    invert_reg  <= cfg_data[0];
                CFG_RX_WHILE_TX:    rx_tx_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Tick arithmetic: millisecond accumulator and symbol timer
    always_comb
    begin
        acc_sum  = {1'b0, micro_reg} + (ACC_W + 1)'(tick_us_reg);
        acc_over = (acc_sum > (ACC_W + 1)'(US_PER_MS));
        acc_adj  = acc_over ? acc_sum - (ACC_W + 1)'(US_PER_MS) : acc_sum;

        tl_zero    = (time_left_reg == '0);
        t_sub      = {time_left_reg[TIME_W-1], time_left_reg}
                     - $signed((TIME_W + 1)'(tick_us_reg));
        want_pop   = tl_zero || (t_sub <= (TIME_W + 1)'(0));
        entry_zero = ring_stat.empty || (ring_stat.head == '0);
        t_base     = tl_zero ? '0 : t_sub;

        if (want_pop)
        begin
            t_pre = {t_base[TIME_W], t_base}
                    + $signed((TIME_W + 2)'(ring_stat.head[DUR_W-1:0]));
        end
        else
        begin
            t_pre = {t_sub[TIME_W], t_sub};
        end

        if (t_pre > (TIME_W + 2)'(TIME_MAX))
        begin
            t_clamped = TIME_W'(TIME_MAX);
        end
        else if (t_pre < $signed((TIME_W + 2)'(TIME_MIN)))
        begin
            t_clamped = TIME_W'(TIME_MIN);
        end
        else
        begin
            t_clamped = t_pre[TIME_W-1:0];
        end
    end

    // Decode the request and form next state
    always_comb
    begin
        time_left_next  = time_left_reg;
        level_next      = level_reg;
        drop_next       = drop_reg;
        micro_next      = micro_reg;
        milli_next      = milli_reg;
        sending         = 1'b0;
        rx_en           = 1'b0;
        accepted        = 1'b0;
        ring_ctrl.push  = 1'b0;
        ring_ctrl.pop   = 1'b0;
        ring_ctrl.clear = 1'b0;
        ring_ctrl.wdata = {1'b0, duration_us & SPACE_MASK};

        case (fn)
            FUNC_MARK, FUNC_SPACE:
            begin
                if (fn == FUNC_MARK)
                begin
                    ring_ctrl.wdata = {1'b1, (DUR_W)'(duration_us[MARK_DUR_W-1:0])};
                end
                ring_ctrl.push = step;
                accepted       = ~ring_stat.full;
                if (ring_stat.full)
                begin
                    drop_next = drop_reg + 1'b1;
                end
            end
            FUNC_CLEAR:
            begin
                ring_ctrl.clear = step;
                time_left_next  = '0;
                level_next      = 1'b0;
                drop_next       = '0;
            end
            FUNC_TICK:
            begin
                micro_next    = acc_adj[ACC_W-1:0];
                milli_next    = milli_reg + MS_W'(acc_over);
                ring_ctrl.pop = step & want_pop;
                sending       = ~tl_zero | ~entry_zero;
                if (want_pop && entry_zero)
                begin
                    time_left_next = '0;
                    level_next     = 1'b0;
                end
                else
                begin
                    time_left_next = t_clamped;
                    if (want_pop)
                    begin
                        level_next = ring_stat.head[MARK_BIT];
                    end
                end
                rx_en = rx_tx_reg | ~sending;
            end
            default: ;
        endcase
    end

    // Commit the state of an accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_left_reg <= '0;
            level_reg     <= 1'b0;
            drop_reg      <= '0;
            micro_reg     <= '0;
            milli_reg     <= '0;
        end
        else if (step)
        begin
            time_left_reg <= time_left_next;
            level_reg     <= level_next;
            drop_reg      <= drop_next;
            micro_reg     <= micro_next;
            milli_reg     <= milli_next;
        end
    end

    // Build the result from the state after the step
    assign qext = QEXT_W'(ring_stat.count_next);

    always_comb
    begin
        result.elapsed_ms     = milli_next;
        result.overflow_count = drop_next;
        result.queue_count    = qext[QCNT_W-1:0];
        result.accepted       = accepted;
        result.receive_enable = rx_en;
        result.sending        = sending;
        result.carrier_on     = level_next;
        if (level_next)
        begin
            result.pwm_compare = duty_reg;
        end
        else
        begin
            result.pwm_compare = invert_reg ? period_reg : '0;
        end
    end

    // A clear leaves the player silent with no drops
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && (fn == FUNC_CLEAR))
        |=> (time_left_reg == '0) && !level_reg && (drop_reg == '0))
        else $error("clear did not reset playback");

    // Only an accepted tick pops the ring
    assert property (@(posedge clk) disable iff (!rst_n)
        ring_ctrl.pop |-> (step && (fn == FUNC_TICK)))
        else $error("pop outside a tick");

    // A dropped push bumps the drop counter by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && ring_stat.full && ((fn == FUNC_MARK) || (fn == FUNC_SPACE)))
        |=> (drop_reg == $past(drop_reg) + 1'b1))
        else $error("dropped push not counted");

endmodule

// ----- hdl/irmsp_out_skid.sv -----
// ----------------------------------------------------------------------------
// irmsp_out_skid
// Two-entry output register that decouples result delivery from intake.
// ----------------------------------------------------------------------------
module irmsp_out_skid (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  irmsp_pkg::result_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output irmsp_pkg::result_t out_data
);
    import irmsp_pkg::*;

    result_t main_reg;
    result_t skid_reg;
    logic    main_valid_reg;
    logic    skid_valid_reg;

    assign in_ready  = ~skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || out_ready)
        begin
            main_valid_reg <= skid_valid_reg | in_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (in_valid && !skid_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Advance payload: refill the output from the skid stage first
    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || out_ready)
        begin
            main_reg <= skid_valid_reg ? skid_reg : in_data;
        end
        else if (in_valid && !skid_valid_reg)
        begin
            skid_reg <= in_data;
        end
    end

    // The skid stage fills only behind a waiting output
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry without output entry");

    // A stalled output keeps its result
    assert property (@(posedge clk) disable iff (!rst_n)
        (main_valid_reg && !out_ready) |=> main_valid_reg && (main_reg == $past(main_reg)))
        else $error("stalled result changed");

endmodule

// ----- hdl/ir_mark_space_player.sv -----
// ----------------------------------------------------------------------------
// ir_mark_space_player
// Infrared mark/space transmit player with a queued symbol ring.
// ----------------------------------------------------------------------------
// Results are registered. Throughput: one request per cycle until both output
// entries fill; the ring memory is read once a cycle into a head register and
// written once a cycle, a same-entry write is forwarded. A two-entry output
// stage keeps intake going while one result waits.
// Reset: asynchronous; clears pointers, counters, timer and output flags and
// loads register defaults. Ring contents are not cleared (no clearing pass).
module ir_mark_space_player (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration
    input  logic                                 cfg_we,
    input  logic [irmsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [irmsp_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Requests
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [27:0] duration_us, [31:28] zero
    input  logic [irmsp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] func
    input  logic [irmsp_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    // Results
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [15:0] pwm_compare, [16] carrier_on, [17] sending, [18] receive_enable,
    // [19] accepted, [27:20] queue_count, [43:28] overflow_count,
    // [75:44] elapsed_ms, [79:76] zero
    output logic [irmsp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import irmsp_pkg::*;

    logic       step;
    ring_ctrl_t ring_ctrl;
    ring_stat_t ring_stat;
    result_t    step_result;
    result_t    out_result;

    assign step = s_axis_tvalid & s_axis_tready;

    irmsp_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ring_ctrl),
        .stat  (ring_stat)
    );

    irmsp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .step        (step),
        .func        (s_axis_tuser[FUNC_W-1:0]),
        .duration_us (s_axis_tdata[DUR_W-1:0]),
        .ring_ctrl   (ring_ctrl),
        .ring_stat   (ring_stat),
        .result      (step_result)
    );

    irmsp_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (step),
        .in_ready  (s_axis_tready),
        .in_data   (step_result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    assign m_axis_tdata = OUT_TDATA_W'(out_result);

endmodule

// ----- sim/tb_ir_mark_space_player.sv -----
// ----------------------------------------------------------------------------
// tb_ir_mark_space_player
// Self-checking bench for the infrared mark/space player. Requests (ticks,
// mark and space pushes, clears) go in on the slave stream with random gaps.
// A scoreboard replays each accepted request on its own copy of the ring,
// playback timer and millisecond clock. It then checks every result on the
// master stream field by field. The register settings change between phases:
// defaults, extreme values, a zero tick, a ring overflow behind a long output
// stall, an odd tick.
// ----------------------------------------------------------------------------
import irmsp_pkg::*;

class player_scoreboard;

    // Register copies
    logic [TICK_W-1:0] tick_us;
    logic [CMP_W-1:0]  carrier_period;
    logic [CMP_W-1:0]  carrier_duty;
    bit                invert_idle;
    bit                rx_while_tx;

    // Player state
    logic [ENTRY_W-1:0] symbol_ring [RING_DEPTH];
    int                 wr_ptr;
    int                 rd_ptr;
    int                 entry_total;
    logic [DROP_W-1:0]  drops;
    longint             time_left;
    bit                 level_on;
    int                 us_accum;
    logic [MS_W-1:0]    ms_clock;

    result_t pending_results [$];
    int      errors;
    int      n_checked;
    int      n_ticks;
    int      n_stored;
    int      n_dropped;
    int      n_clears;
    int      max_fill;

    function new();
        tick_us        = TICK_US_RST;
        carrier_period = PERIOD_RST;
        carrier_duty   = DUTY_RST;
        invert_idle    = 1'b0;
        rx_while_tx    = 1'b0;
        clear_ring();
        us_accum  = 0;
        ms_clock  = '0;
        errors    = 0;
        n_checked = 0;
        n_ticks   = 0;
        n_stored  = 0;
        n_dropped = 0;
        n_clears  = 0;
        max_fill  = 0;
    endfunction

    function void clear_ring();
        wr_ptr      = 0;
        rd_ptr      = 0;
        entry_total = 0;
        drops       = '0;
        time_left   = 0;
        level_on    = 1'b0;
    endfunction

    function void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_TICK_US:        tick_us        = value[TICK_W-1:0];
            CFG_CARRIER_PERIOD: carrier_period = value[CMP_W-1:0];
            CFG_CARRIER_DUTY:   carrier_duty   = value[CMP_W-1:0];
            CFG_INVERT_IDLE:    invert_idle    = value[0];
            CFG_RX_WHILE_TX:    rx_while_tx    = value[0];
            default: ;
        endcase
    endfunction

    // Store an entry unless the ring already holds depth-1 entries
    function bit ring_push(logic [ENTRY_W-1:0] value);
        if (entry_total >= RING_DEPTH - 1)
        begin
            drops++;
            n_dropped++;
            return 1'b0;
        end
        symbol_ring[wr_ptr] = value;
        wr_ptr = (wr_ptr + 1) % RING_DEPTH;
        entry_total++;
        n_stored++;
        if (entry_total > max_fill)
            max_fill = entry_total;
        return 1'b1;
    endfunction

    // Take the head entry; an empty ring reads as zero
    function logic [ENTRY_W-1:0] ring_pop();
        logic [ENTRY_W-1:0] value;
        if (entry_total == 0)
            return '0;
        value = symbol_ring[rd_ptr];
        rd_ptr = (rd_ptr + 1) % RING_DEPTH;
        entry_total--;
        return value;
    endfunction

    // Advance the player by one request and build its result
    function result_t player_step(func_t f, logic [DUR_W-1:0] d);
        result_t            r;
        logic [ENTRY_W-1:0] e;
        longint             t;
        r = '0;
        case (f)
            FUNC_MARK:  r.accepted = ring_push({1'b1, 12'd0, d[MARK_DUR_W-1:0]});
            FUNC_SPACE: r.accepted = ring_push({1'b0, d & SPACE_MASK});
            FUNC_CLEAR:
            begin
                clear_ring();
                n_clears++;
            end
            default:
            begin
                n_ticks++;
                // millisecond clock
                us_accum = us_accum + int'(tick_us);
                if (us_accum > US_PER_MS)
                begin
                    ms_clock++;
                    us_accum = us_accum - US_PER_MS;
                end
                us_accum = us_accum & 'h7ff;
                // playback timer, overshoot carried into the next symbol
                if (time_left != 0)
                begin
                    t = time_left - longint'(tick_us);
                    r.sending = 1'b1;
                    if (t <= 0)
                    begin
                        e = ring_pop();
                        if (e == '0)
                        begin
                            t = 0;
                            level_on = 1'b0;
                        end
                        else
                        begin
                            level_on = e[MARK_BIT];
                            t = t + longint'(e[DUR_W-1:0]);
                        end
                    end
                    if (t > TIME_MAX)
                        t = TIME_MAX;
                    else if (t < TIME_MIN)
                        t = TIME_MIN;
                    time_left = t;
                end
                else
                begin
                    e = ring_pop();
                    if (e == '0)
                    begin
                        time_left = 0;
                        level_on = 1'b0;
                    end
                    else
                    begin
                        r.sending = 1'b1;
                        time_left = longint'(e[DUR_W-1:0]);
                        level_on = e[MARK_BIT];
                    end
                end
                r.receive_enable = rx_while_tx || !r.sending;
            end
        endcase
        if (level_on)
            r.pwm_compare = carrier_duty;
        else
            r.pwm_compare = invert_idle ? carrier_period : '0;
        r.carrier_on     = level_on;
        r.queue_count    = QCNT_W'(entry_total);
        r.overflow_count = drops;
        r.elapsed_ms     = ms_clock;
        return r;
    endfunction

    function void note_request(func_t f, logic [DUR_W-1:0] d);
        pending_results.push_back(player_step(f, d));
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h",
                     $time, field, want, got);
        end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data);
        result_t want;
        result_t got;
        got = data[$bits(result_t)-1:0];
        if (pending_results.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result, expected none actual 0x%0h",
                     $time, data);
            return;
        end
        want = pending_results.pop_front();
        n_checked++;
        compare_field("pwm_compare", want.pwm_compare, got.pwm_compare);
        compare_field("carrier_on", want.carrier_on, got.carrier_on);
        compare_field("sending", want.sending, got.sending);
        compare_field("receive_enable", want.receive_enable, got.receive_enable);
        compare_field("accepted", want.accepted, got.accepted);
        compare_field("queue_count", want.queue_count, got.queue_count);
        compare_field("overflow_count", want.overflow_count, got.overflow_count);
        compare_field("elapsed_ms", want.elapsed_ms, got.elapsed_ms);
        compare_field("padding", '0, data[OUT_TDATA_W-1:$bits(result_t)]);
    endfunction

endclass

module tb_ir_mark_space_player;

    localparam int CLK_PERIOD   = 20;
    localparam int LIMIT_CYCLES = 400000;
    localparam int BURST_HOLD   = 300;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    logic [IN_TUSER_W-1:0]   s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;

    player_scoreboard sb = new();
    bit               no_idle    = 1'b0;
    bit               hold_burst = 1'b0;

    ir_mark_space_player u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Offer one request after a random gap, hold until taken
    task automatic send_req(func_t f, logic [DUR_W-1:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= {{(IN_TDATA_W - DUR_W){1'b0}}, d};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(f, d);
        @(negedge clk);
    endtask

    // Duration often scaled to the tick so that symbols end within a few ticks
    function automatic logic [DUR_W-1:0] pick_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 72)
            return DUR_W'($urandom_range(1, 4 * int'(sb.tick_us) + 4));
        if (r < 96)
            return DUR_W'($urandom_range(0, 65535));
        return DUR_W'($urandom);
    endfunction

    task automatic run_random(int n);
        int r;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                send_req(FUNC_TICK, DUR_W'($urandom));
            else if (r < 72)
                send_req(FUNC_MARK, pick_duration());
            else if (r < 94)
                send_req(FUNC_SPACE, pick_duration());
            else
                send_req(FUNC_CLEAR, DUR_W'($urandom));
        end
    endtask

    // Drop valid, drain all results, let the pipeline empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        sb.set_register(idx, value);
    endtask

    task automatic configure(logic [TICK_W-1:0] tick, logic [CMP_W-1:0] period,
                             logic [CMP_W-1:0] duty, bit inv, bit rx);
        write_register(CFG_TICK_US, CFG_DATA_W'(tick));
        write_register(CFG_CARRIER_PERIOD, period);
        write_register(CFG_CARRIER_DUTY, duty);
        write_register(CFG_INVERT_IDLE, CFG_DATA_W'(inv));
        write_register(CFG_RX_WHILE_TX, CFG_DATA_W'(rx));
        cfg_we <= 1'b0;
    endtask

    // Receiver: random stalls, plus one long hold on request
    initial
    begin : result_sink
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_burst)
            begin
                hold_burst = 1'b0;
                stall = BURST_HOLD;
            end
            else if (stall == 0 && $urandom_range(0, 3) == 0)
            begin
                stall = pick_gap();
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Check every result taken
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Main sequence
    initial
    begin : stimulus
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, register defaults: idle tick, clear on empty, masked
        // mark, zero-length mark, overshoot, zero space stop, playback
        // running out, max space, clear during playback
        send_req(FUNC_TICK, '0);
        send_req(FUNC_CLEAR, '0);
        send_req(FUNC_MARK, 28'h0ABC_0064);
        send_req(FUNC_MARK, '0);
        send_req(FUNC_SPACE, 28'd30);
        send_req(FUNC_SPACE, '0);
        send_req(FUNC_MARK, 28'd40);
        repeat (8) send_req(FUNC_TICK, 28'hFFF_FFFF);
        send_req(FUNC_SPACE, 28'hFFF_FFFF);
        send_req(FUNC_TICK, '0);
        send_req(FUNC_TICK, '0);
        send_req(FUNC_CLEAR, 28'hFFF_FFFF);
        send_req(FUNC_TICK, '0);
        send_req(FUNC_MARK, 28'hFFF_FFFF);
        send_req(FUNC_TICK, '0);
        send_req(FUNC_CLEAR, '0);
        settle();

        // Millisecond tick, zero duty, full period on idle, receiver always on
        configure(10'd1000, 16'hFFFF, 16'h0000, 1'b1, 1'b1);
        run_random(50);
        settle();

        // One-microsecond tick, duty above period; fill the ring past full, starting
        // with a long hold on the output
        configure(10'd1, 16'd1, 16'hFFFF, 1'b0, 1'b0);
        no_idle = 1'b1;
        send_req(FUNC_CLEAR, '0);
        hold_burst = 1'b1;
        repeat (RING_DEPTH + 6)
        begin
            if ($urandom_range(0, 1) == 0)
                send_req(FUNC_MARK, DUR_W'($urandom));
            else
                send_req(FUNC_SPACE, DUR_W'($urandom_range(0, 3)));
        end
        repeat (12) send_req(FUNC_TICK, '0);
        send_req(FUNC_CLEAR, '0);
        no_idle = 1'b0;
        settle();

        // Zero tick: no time passes
        configure(10'd0, 16'h1234, 16'h0800, 1'b1, 1'b0);
        run_random(30);
        settle();

        // Widest tick value
        configure(10'h3FF, 16'h5555, 16'hAAAA, 1'b1, 1'b0);
        run_random(50);
        settle();

        // Odd tick, default carrier
        configure(10'd37, 16'd684, 16'd342, 1'b0, 1'b1);
        run_random(40);
        settle();

        $display("Covered %0d results: %0d ticks, %0d stored, %0d dropped, %0d clears",
                 sb.n_checked, sb.n_ticks, sb.n_stored, sb.n_dropped, sb.n_clears);
        $display("Deepest ring fill %0d, six register settings", sb.max_fill);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #(longint'(LIMIT_CYCLES) * CLK_PERIOD);
        $display("Timeout with %0d results outstanding", sb.pending_results.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
